// ===== sv/apfp_pkg.sv =====
// Shared types and constants for the audio presented frame projector.
// Used by every module of the block; depends on nothing else.
package apfp_pkg;

    localparam int FRAME_W = 64;
    localparam int MS_W    = 32;
    localparam int RATE_W  = 19;

    localparam logic [RATE_W-1:0] RATE_RESET = 19'd48000;

    // Nanoseconds to milliseconds is done one 16-bit digit per step.
    // The top digit is always below one million, so it needs no step.
    localparam int DIV_STEPS = 3;
    localparam int DIGIT_W   = 16;
    localparam int REM_W     = 20;
    localparam logic [REM_W-1:0] NS_PER_MS = 20'd1000000;
    // floor(x / 15625) for x below 2**30 equals (x * magic) >> 44.
    localparam logic [30:0] DIV15625_MAGIC = 31'd1125899907;
    localparam int DIV15625_SHIFT = 44;

    // floor(x / 1000) for any 32-bit x equals (x * magic) >> 38.
    localparam logic [9:0]  MS_PER_S      = 10'd1000;
    localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
    localparam int DIV1000_SHIFT = 38;

    typedef enum logic [1:0] {
        OP_PHYS  = 2'd0,
        OP_LOGIC = 2'd1,
        OP_QUERY = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        KIND_STORED = 3'd0,
        KIND_REJECT = 3'd1,
        KIND_FRAME  = 3'd2,
        KIND_REPEAT = 3'd3,
        KIND_NONE   = 3'd4
    } kind_t;

    // One word as it travels down the pipeline after the decision stage.
    typedef struct packed {
        kind_t              kind;
        logic               upd_ms;  // accepted publish: load anchor time
        logic               phys;    // anchor time comes from the ns divider
        logic [63:0]        ns;
        logic [MS_W-1:0]    ms;      // logical anchor time or query time
        logic [FRAME_W-1:0] frame;   // anchor frame for a projection
        logic [FRAME_W-1:0] room;    // tail minus frame minus one
    } item_t;

endpackage

// ===== sv/apfp_ctrl.sv =====
// Input register and decision stage: anchor checks, sticky invalidation,
// anchor frame and tail storage. Depends on apfp_pkg.
module apfp_ctrl
    import apfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               s_valid,
    input  logic [1:0]         s_opcode,
    input  logic [FRAME_W-1:0] s_presented_frame,
    input  logic [FRAME_W-1:0] s_submitted_tail,
    input  logic [63:0]        s_system_time_ns,
    input  logic [MS_W-1:0]    s_anchor_time_ms,
    input  logic [MS_W-1:0]    s_now_ms,
    output logic               out_valid,
    output item_t              out_item
);

    logic               in_valid_reg;
    logic [1:0]         op_reg;
    logic [FRAME_W-1:0] pf_reg;
    logic [FRAME_W-1:0] tail_reg;
    logic [63:0]        ns_reg;
    logic [MS_W-1:0]    atm_reg;
    logic [MS_W-1:0]    now_reg;

    logic               invalid_reg, invalid_next;
    logic               present_reg, present_next;
    logic               answered_reg, answered_next;
    logic [FRAME_W-1:0] anc_frame_reg, anc_frame_next;
    logic [FRAME_W-1:0] anc_tail_reg, anc_tail_next;

    logic               out_valid_reg;
    item_t              item_reg, item_next;
    logic               bad_publish;

    always_comb begin
        bad_publish    = invalid_reg || (tail_reg <= pf_reg);
        invalid_next   = invalid_reg;
        present_next   = present_reg;
        answered_next  = answered_reg;
        anc_frame_next = anc_frame_reg;
        anc_tail_next  = anc_tail_reg;

        item_next        = '0;
        item_next.kind   = KIND_NONE;
        item_next.ns     = ns_reg;
        item_next.frame  = anc_frame_reg;
        item_next.room   = anc_tail_reg - anc_frame_reg - 64'd1;

        case (opcode_t'(op_reg))
            OP_PHYS, OP_LOGIC: begin
                if (bad_publish || (op_reg == OP_PHYS && ns_reg == 64'd0)) begin
                    invalid_next   = 1'b1;
                    item_next.kind = KIND_REJECT;
                end else begin
                    anc_frame_next   = pf_reg;
                    anc_tail_next    = tail_reg;
                    present_next     = 1'b1;
                    item_next.kind   = KIND_STORED;
                    item_next.upd_ms = 1'b1;
                    item_next.phys   = (op_reg == OP_PHYS);
                    item_next.ms     = atm_reg;
                end
            end
            OP_QUERY: begin
                item_next.ms = now_reg;
                if (invalid_reg) begin
                    item_next.kind = KIND_REJECT;
                end else if (!present_reg) begin
                    item_next.kind = answered_reg ? KIND_REPEAT : KIND_NONE;
                end else begin
                    item_next.kind = KIND_FRAME;
                    answered_next  = 1'b1;
                end
            end
            default: begin
                item_next.kind = KIND_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            invalid_reg   <= 1'b0;
            present_reg   <= 1'b0;
            answered_reg  <= 1'b0;
        end else if (en) begin
            in_valid_reg  <= s_valid;
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                invalid_reg  <= invalid_next;
                present_reg  <= present_next;
                answered_reg <= answered_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg   <= s_opcode;
            pf_reg   <= s_presented_frame;
            tail_reg <= s_submitted_tail;
            ns_reg   <= s_system_time_ns;
            atm_reg  <= s_anchor_time_ms;
            now_reg  <= s_now_ms;
            item_reg <= item_next;
            if (in_valid_reg) begin
                anc_frame_reg <= anc_frame_next;
                anc_tail_reg  <= anc_tail_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== sv/apfp_ms_div.sv =====
// Pipelined nanosecond to millisecond divider, one 16-bit quotient digit
// per pair of stages; every word rides along. Depends on apfp_pkg.
module apfp_ms_div
    import apfp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  item_t in_item,
    output logic  out_valid,
    output item_t out_item
);

    logic               va_reg   [DIV_STEPS];
    item_t              ita_reg  [DIV_STEPS];
    logic [35:0]        num_reg  [DIV_STEPS];
    logic [DIGIT_W-1:0] qa_reg   [DIV_STEPS];
    logic [MS_W-1:0]    quoa_reg [DIV_STEPS];

    logic               vb_reg   [DIV_STEPS];
    item_t              itb_reg  [DIV_STEPS];
    logic [REM_W-1:0]   remb_reg [DIV_STEPS];
    logic [MS_W-1:0]    quob_reg [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++) begin : g_step
            logic               src_valid;
            item_t              src_item;
            logic [REM_W-1:0]   src_rem;
            logic [MS_W-1:0]    src_quo;
            logic [35:0]        num;
            logic [60:0]        qprod;
            logic [35:0]        qm;
            logic [35:0]        rem_full;

            if (k == 0) begin : g_first
                assign src_valid = in_valid;
                assign src_item  = in_item;
                assign src_rem   = {4'd0, in_item.ns[63:48]};
                assign src_quo   = '0;
            end else begin : g_next
                assign src_valid = vb_reg[k-1];
                assign src_item  = itb_reg[k-1];
                assign src_rem   = remb_reg[k-1];
                assign src_quo   = quob_reg[k-1];
            end

            // Dividing by one million is a shift by six, then by 15625.
            assign num      = {src_rem, src_item.ns[47-DIGIT_W*k -: DIGIT_W]};
            assign qprod    = 61'(num[35:6]) * 61'(DIV15625_MAGIC);
            assign qm       = 36'(qa_reg[k]) * 36'(NS_PER_MS);
            assign rem_full = num_reg[k] - qm;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    va_reg[k] <= 1'b0;
                    vb_reg[k] <= 1'b0;
                end else if (en) begin
                    va_reg[k] <= src_valid;
                    vb_reg[k] <= va_reg[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    ita_reg[k]  <= src_item;
                    num_reg[k]  <= num;
                    qa_reg[k]   <= qprod[DIV15625_SHIFT+DIGIT_W-1:DIV15625_SHIFT];
                    quoa_reg[k] <= src_quo;
                    itb_reg[k]  <= ita_reg[k];
                    remb_reg[k] <= rem_full[REM_W-1:0];
                    quob_reg[k] <= {quoa_reg[k][MS_W-DIGIT_W-1:0], qa_reg[k]};
                end
            end
        end
    endgenerate

    always_comb begin
        out_item = itb_reg[DIV_STEPS-1];
        if (out_item.phys) begin
            out_item.ms = quob_reg[DIV_STEPS-1];
        end
    end

    assign out_valid = vb_reg[DIV_STEPS-1];

endmodule

// ===== sv/apfp_proj.sv =====
// Projection pipeline: elapsed time against the stored anchor time, scaling
// by the sample rate, division by 1000 and clamping. Depends on apfp_pkg.
module apfp_proj
    import apfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [RATE_W-1:0]  rate,
    input  logic               in_valid,
    input  item_t              in_item,
    output logic               out_valid,
    output item_t              out_item,
    output logic [FRAME_W-1:0] out_proj
);

    localparam int STAGES = 6;

    logic [STAGES-1:0]  vld_reg;
    item_t              it_reg [STAGES];
    logic [MS_W-1:0]    anchor_ms_reg;

    logic [MS_W-1:0]    diff;
    logic [30:0]        elapsed;
    logic [30:0]        e0_reg, e1_reg;
    logic [59:0]        prod1;
    logic [21:0]        a_reg;
    logic [31:0]        am;
    logic [30:0]        bdiff;
    logic [9:0]         b_reg;
    logic [40:0]        ar2_reg, ar3_reg, ar4_reg;
    logic [28:0]        br_reg;
    logic [57:0]        prod4;
    logic [19:0]        c_reg;
    logic [41:0]        sum;
    logic [FRAME_W-1:0] sum_ext;
    logic [FRAME_W-1:0] proj_reg;

    // A backward clock, seen as a negative difference, counts as no time.
    assign diff    = in_item.ms - anchor_ms_reg;
    assign elapsed = diff[31] ? 31'd0 : diff[30:0];

    assign prod1   = 60'(e0_reg) * 60'(DIV1000_MAGIC);
    assign am      = 32'(a_reg) * 32'(MS_PER_S);
    assign bdiff   = e1_reg - am[30:0];
    assign prod4   = 58'(br_reg) * 58'(DIV1000_MAGIC);
    assign sum     = 42'(ar4_reg) + 42'(c_reg);
    assign sum_ext = {{(FRAME_W-42){1'b0}}, sum};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it_reg[0] <= in_item;
            for (int i = 1; i < STAGES; i++) begin
                it_reg[i] <= it_reg[i-1];
            end
            if (in_valid && in_item.upd_ms) begin
                anchor_ms_reg <= in_item.ms;
            end
            e0_reg   <= elapsed;
            a_reg    <= prod1[DIV1000_SHIFT+21:DIV1000_SHIFT];
            e1_reg   <= e0_reg;
            b_reg    <= bdiff[9:0];
            ar2_reg  <= 41'(a_reg) * 41'(rate);
            br_reg   <= 29'(b_reg) * 29'(rate);
            ar3_reg  <= ar2_reg;
            c_reg    <= prod4[DIV1000_SHIFT+19:DIV1000_SHIFT];
            ar4_reg  <= ar3_reg;
            proj_reg <= (sum_ext > it_reg[4].room) ? it_reg[4].room : sum_ext;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_item  = it_reg[STAGES-1];
    assign out_proj  = proj_reg;

endmodule

// ===== sv/apfp_out.sv =====
// Result stage: adds the projection to the anchor frame, keeps the answer
// monotonic and holds the result register. Depends on apfp_pkg.
module apfp_out
    import apfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  item_t              in_item,
    input  logic [FRAME_W-1:0] in_proj,
    output logic               m_valid,
    output logic [2:0]         m_result_kind,
    output logic               m_frame_valid,
    output logic [FRAME_W-1:0] m_current_frame
);

    logic               valid_reg;
    kind_t              kind_reg;
    logic               fv_reg, fv_next;
    logic [FRAME_W-1:0] cf_reg, cf_next;
    logic [FRAME_W-1:0] last_reg;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] answer;

    assign frame  = in_item.frame + in_proj;
    assign answer = (frame > last_reg) ? frame : last_reg;

    always_comb begin
        case (in_item.kind)
            KIND_FRAME: begin
                fv_next = 1'b1;
                cf_next = answer;
            end
            KIND_REPEAT: begin
                fv_next = 1'b1;
                cf_next = last_reg;
            end
            default: begin
                fv_next = 1'b0;
                cf_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            last_reg  <= '0;
        end else if (en) begin
            valid_reg <= in_valid;
            if (in_valid && in_item.kind == KIND_FRAME) begin
                last_reg <= answer;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            kind_reg <= in_item.kind;
            fv_reg   <= fv_next;
            cf_reg   <= cf_next;
        end
    end

    assign m_valid         = valid_reg;
    assign m_result_kind   = kind_reg;
    assign m_frame_valid   = fv_reg;
    assign m_current_frame = cf_reg;

endmodule

// ===== sv/audio_presented_frame_projector_unit.sv =====
// Audio presented frame projector, top level. Depends on apfp_pkg and the apfp_* modules.
// The pipeline is made of the input and decision stages, six divider stages, six projection
// stages and the result register. Throughput: one word per cycle; the whole pipeline holds
// while a result waits. Reset (synchronous, active low) empties the pipeline, clears the
// anchor, the invalidated flag and the last answer, and sets the sample rate to 48000.
module audio_presented_frame_projector_unit
    import apfp_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [FRAME_W-1:0] s_presented_frame,
    input  logic [FRAME_W-1:0] s_submitted_tail,
    input  logic [63:0]        s_system_time_ns,
    input  logic [MS_W-1:0]    s_anchor_time_ms,
    input  logic [MS_W-1:0]    s_now_ms,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_result_kind,
    output logic               m_frame_valid,
    output logic [FRAME_W-1:0] m_current_frame,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RATE_W-1:0]  cfg_sample_rate
);

    logic               en;
    logic [RATE_W-1:0]  rate_reg;
    logic               ctrl_valid, div_valid, proj_valid;
    item_t              ctrl_item, div_item, proj_item;
    logic [FRAME_W-1:0] proj_value;

    // Every stage advances together whenever the result register is free.
    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
        end else if (cfg_valid) begin
            rate_reg <= cfg_sample_rate;
        end
    end

    apfp_ctrl u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .en                (en),
        .s_valid           (s_valid),
        .s_opcode          (s_opcode),
        .s_presented_frame (s_presented_frame),
        .s_submitted_tail  (s_submitted_tail),
        .s_system_time_ns  (s_system_time_ns),
        .s_anchor_time_ms  (s_anchor_time_ms),
        .s_now_ms          (s_now_ms),
        .out_valid         (ctrl_valid),
        .out_item          (ctrl_item)
    );

    apfp_ms_div u_ms_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ctrl_valid),
        .in_item   (ctrl_item),
        .out_valid (div_valid),
        .out_item  (div_item)
    );

    apfp_proj u_proj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .rate      (rate_reg),
        .in_valid  (div_valid),
        .in_item   (div_item),
        .out_valid (proj_valid),
        .out_item  (proj_item),
        .out_proj  (proj_value)
    );

    apfp_out u_out (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .in_valid        (proj_valid),
        .in_item         (proj_item),
        .in_proj         (proj_value),
        .m_valid         (m_valid),
        .m_result_kind   (m_result_kind),
        .m_frame_valid   (m_frame_valid),
        .m_current_frame (m_current_frame)
    );

endmodule

// ===== tb/tb_audio_presented_frame_projector_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for audio_presented_frame_projector_unit: directed rows, random
// words under three idling mixes and noisy words, each result checked against the table
// or a local predictor. Depends on apfp_pkg and the RTL of the block.
module tb_audio_presented_frame_projector_unit;
    import apfp_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int PIPE_LATENCY = 14;
    localparam int LIMIT_CYCLES = 250000;
    localparam int N_BLOCKS     = 6;
    localparam int BLOCK_WORDS  = 215;
    localparam int NOISY_WORDS  = 100;
    localparam int STALL_CYCLES = 300;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Row ranges of the directed table.
    localparam int EARLY_END   = 15;
    localparam int EXTREME_END = 17;

    typedef struct {
        logic [1:0]         op;
        logic [FRAME_W-1:0] frame;
        logic [FRAME_W-1:0] tail;
        logic [63:0]        ns;
        logic [MS_W-1:0]    ams;
        logic [MS_W-1:0]    now;
    } word_t;

    typedef struct {
        kind_t              kind;
        logic               frame_valid;
        logic [FRAME_W-1:0] frame;
    } result_t;

    typedef struct {
        word_t   w;
        logic    typed;
        result_t want;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_opcode;
    logic [FRAME_W-1:0] s_presented_frame;
    logic [FRAME_W-1:0] s_submitted_tail;
    logic [63:0]        s_system_time_ns;
    logic [MS_W-1:0]    s_anchor_time_ms;
    logic [MS_W-1:0]    s_now_ms;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_result_kind;
    logic               m_frame_valid;
    logic [FRAME_W-1:0] m_current_frame;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [RATE_W-1:0]  cfg_sample_rate;

    audio_presented_frame_projector_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_presented_frame (s_presented_frame),
        .s_submitted_tail  (s_submitted_tail),
        .s_system_time_ns  (s_system_time_ns),
        .s_anchor_time_ms  (s_anchor_time_ms),
        .s_now_ms          (s_now_ms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_result_kind     (m_result_kind),
        .m_frame_valid     (m_frame_valid),
        .m_current_frame   (m_current_frame),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_sample_rate   (cfg_sample_rate)
    );

    // Predictor state.
    logic [RATE_W-1:0]  rate_model;
    logic               invalidated;
    logic               have_anchor;
    logic [FRAME_W-1:0] anc_frame;
    logic [FRAME_W-1:0] anc_tail;
    logic [MS_W-1:0]    anc_ms;
    logic [FRAME_W-1:0] best_frame;
    logic               answered;

    // Random stream position, so that publishes and queries stay close to one another.
    logic [FRAME_W-1:0] stream_base;
    logic [MS_W-1:0]    stream_ms;

    result_t   pending_results[$];
    stim_row_t stim_table[$];

    int src_idle_pct;
    int sink_idle_pct;
    int stall_req_id;
    int mismatch_count;
    int unsigned cycle_count;

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic result_t project_word(input word_t w);
        result_t     r;
        logic [63:0] ns_ms;
        logic [31:0] t_ms;
        logic [31:0] elapsed;
        logic [63:0] proj;
        logic [63:0] room;
        logic [63:0] frame;
        logic        bad;
        r.kind = KIND_NONE;
        r.frame_valid = 1'b0;
        r.frame = '0;
        case (w.op)
            OP_PHYS, OP_LOGIC: begin
                ns_ms = w.ns / 64'(NS_PER_MS);
                t_ms = (w.op == OP_PHYS) ? ns_ms[31:0] : w.ams;
                bad = invalidated || (w.tail <= w.frame) || (w.op == OP_PHYS && w.ns == '0);
                if (bad) begin
                    invalidated = 1'b1;
                    r.kind = KIND_REJECT;
                end else begin
                    anc_frame = w.frame;
                    anc_tail = w.tail;
                    anc_ms = t_ms;
                    have_anchor = 1'b1;
                    r.kind = KIND_STORED;
                end
            end
            OP_QUERY: begin
                if (invalidated) begin
                    r.kind = KIND_REJECT;
                end else if (!have_anchor) begin
                    if (answered) begin
                        r.kind = KIND_REPEAT;
                        r.frame_valid = 1'b1;
                        r.frame = best_frame;
                    end
                end else begin
                    elapsed = w.now - anc_ms;
                    // A clock that went backward counts as no time elapsed.
                    if (elapsed > 32'h7FFF_FFFF)
                        elapsed = '0;
                    proj = 64'(elapsed) * 64'(rate_model) / 64'(MS_PER_S);
                    room = anc_tail - anc_frame - 64'd1;
                    if (proj > room)
                        proj = room;
                    frame = anc_frame + proj;
                    if (frame > best_frame)
                        best_frame = frame;
                    answered = 1'b1;
                    r.kind = KIND_FRAME;
                    r.frame_valid = 1'b1;
                    r.frame = best_frame;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic word_t well_formed_word();
        word_t       w;
        int unsigned pick;
        int unsigned shape;
        logic [63:0] room;
        logic [63:0] back;
        logic [63:0] ns_ms;
        logic [31:0] elapsed;
        w.op = OP_QUERY;
        w.frame = rand64();
        w.tail = rand64();
        w.ns = rand64();
        w.ams = $urandom;
        w.now = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            w.op = OP_UNUSED;
        end else if (pick < 30) begin
            w.op = ($urandom_range(0, 1) == 0) ? OP_PHYS : OP_LOGIC;
            back = 64'($urandom_range(0, 200000));
            // Now and then the anchor lands below the last answer.
            if ($urandom_range(0, 4) == 0)
                w.frame = (stream_base > back) ? stream_base - back : '0;
            else
                w.frame = stream_base + 64'($urandom_range(0, 1000));
            shape = $urandom_range(0, 99);
            if (shape < 25)
                room = 64'($urandom_range(1, 4));
            else if (shape < 65)
                room = 64'($urandom_range(1, 500000));
            else if (shape < 85)
                room = {32'd0, $urandom} + 64'd1;
            else
                room = (rand64() >> 2) + 64'd1;
            w.tail = w.frame + room;
            stream_base = stream_base + 64'($urandom_range(1000, 60000));
            if (w.op == OP_LOGIC) begin
                if ($urandom_range(0, 4) == 0)
                    stream_ms = $urandom;
                else
                    stream_ms = stream_ms + 32'($urandom_range(0, 3000));
                w.ams = stream_ms;
            end else begin
                if ($urandom_range(0, 6) == 0)
                    w.ns = rand64() | 64'd1;
                else
                    w.ns = 64'(stream_ms) * 64'(NS_PER_MS) + 64'($urandom_range(0, 999999))
                         + 64'($urandom_range(0, 3000)) * 64'(NS_PER_MS) + 64'd1;
                ns_ms = w.ns / 64'(NS_PER_MS);
                stream_ms = ns_ms[31:0];
            end
        end else begin
            shape = $urandom_range(0, 99);
            if (shape < 70)
                elapsed = 32'($urandom_range(0, 4000));
            else if (shape < 80)
                elapsed = $urandom;
            else if (shape < 85)
                elapsed = 32'h7FFF_FFFF - 32'($urandom_range(0, 2));
            else if (shape < 90)
                elapsed = 32'h8000_0000 + 32'($urandom_range(0, 2));
            else
                elapsed = 32'($urandom_range(0, 200000));
            w.now = stream_ms + elapsed;
        end
        return w;
    endfunction

    // Full-range fields with malformed publishes mixed in; the first one invalidates.
    function automatic word_t noisy_word();
        word_t       w;
        int unsigned shape;
        w.op = 2'($urandom_range(0, 3));
        w.frame = rand64();
        w.ns = ($urandom_range(0, 9) == 0) ? '0 : rand64();
        w.ams = $urandom;
        w.now = $urandom;
        shape = $urandom_range(0, 9);
        if (shape == 0 || w.frame == '1)
            w.tail = w.frame;
        else if (shape == 1)
            w.tail = rand64();
        else
            w.tail = w.frame + 64'd1 + rand64() % (~w.frame);
        return w;
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [63:0] frame,
                                    input logic [63:0] tail, input logic [63:0] ns,
                                    input logic [31:0] ams, input logic [31:0] now,
                                    input logic typed, input kind_t kind,
                                    input logic fvalid, input logic [63:0] cur);
        stim_row_t row;
        row.w.op = op;
        row.w.frame = frame;
        row.w.tail = tail;
        row.w.ns = ns;
        row.w.ams = ams;
        row.w.now = now;
        row.typed = typed;
        row.want.kind = kind;
        row.want.frame_valid = fvalid;
        row.want.frame = cur;
        stim_table.push_back(row);
    endfunction

    // Called right after a falling edge or a handshake; returns at the accepting edge.
    task automatic send_word(input word_t w, input logic typed, input result_t want);
        result_t got;
        @(negedge aclk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= w.op;
        s_presented_frame <= w.frame;
        s_submitted_tail <= w.tail;
        s_system_time_ns <= w.ns;
        s_anchor_time_ms <= w.ams;
        s_now_ms <= w.now;
        do @(posedge aclk); while (!s_ready);
        got = project_word(w);
        pending_results.push_back(typed ? want : got);
    endtask

    task automatic walk_rows(input int first, input int last);
        for (int i = first; i < last; i++)
            send_word(stim_table[i].w, stim_table[i].typed, stim_table[i].want);
    endtask

    task automatic end_stream();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] rate);
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 2) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_sample_rate <= rate;
        do @(posedge aclk); while (!cfg_ready);
        rate_model = rate;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random back-pressure, plus long hold-offs on request.
    int stall_cycles_req;
    initial begin
        int hold_left;
        int seen_id;
        hold_left = 0;
        seen_id = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_req_id != seen_id) begin
                seen_id = stall_req_id;
                hold_left = stall_cycles_req;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result word with none expected: kind %0d frame %0h",
                         $time, m_result_kind, m_current_frame);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_result_kind !== want.kind) begin
                    $display("%0t: result_kind expected %0d actual %0d",
                             $time, want.kind, m_result_kind);
                    mismatch_count++;
                end
                if (m_frame_valid !== want.frame_valid) begin
                    $display("%0t: frame_valid expected %0d actual %0d",
                             $time, want.frame_valid, m_frame_valid);
                    mismatch_count++;
                end
                if (m_current_frame !== want.frame) begin
                    $display("%0t: current_frame expected %0h actual %0h",
                             $time, want.frame, m_current_frame);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] block_rates [N_BLOCKS];
        result_t           none_res;

        none_res.kind = KIND_NONE;
        none_res.frame_valid = 1'b0;
        none_res.frame = '0;
        block_rates = '{19'd1, 19'd384000, 19'd0, 19'h7FFFF, 19'd44100, RATE_RESET};

        // Early rows: no anchor yet, then projections, clamping and backward clocks.
        add_row(OP_QUERY, 0, 0, 0, 0, 0, 1'b1, KIND_NONE, 1'b0, 0);
        add_row(OP_UNUSED, 0, 0, 0, 0, 0, 1'b1, KIND_NONE, 1'b0, 0);
        add_row(OP_UNUSED, '1, '1, '1, '1, '1, 1'b1, KIND_NONE, 1'b0, 0);
        add_row(OP_LOGIC, 1000, 101000, 0, 5000, 0, 1'b1, KIND_STORED, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, 5000, 1'b1, KIND_FRAME, 1'b1, 1000);
        add_row(OP_QUERY, 0, 0, 0, 0, 6000, 1'b0, KIND_NONE, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, 32'h8000_1388, 1'b0, KIND_NONE, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, 4999, 1'b0, KIND_NONE, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, 32'h8000_1387, 1'b0, KIND_NONE, 1'b0, 0);
        add_row(OP_PHYS, 200000, 200001, 1, 0, 0, 1'b1, KIND_STORED, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, 12345, 1'b0, KIND_NONE, 1'b0, 0);
        add_row(OP_PHYS, 300000, '1, '1, 0, 0, 1'b1, KIND_STORED, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0,
                32'(64'hFFFF_FFFF_FFFF_FFFF / 64'(NS_PER_MS)) + 32'd1000,
                1'b0, KIND_NONE, 1'b0, 0);
        add_row(OP_LOGIC, 0, 1, 0, '1, 0, 1'b1, KIND_STORED, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, 0, 1'b0, KIND_NONE, 1'b0, 0);
        // Largest frames; the answer is pinned near the top from here on.
        add_row(OP_LOGIC, 64'hFFFF_FFFF_FFFF_FFFE, '1, 0, 0, 0, 1'b1, KIND_STORED, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, '1, 1'b1, KIND_FRAME, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);
        // Invalidation is sticky until reset, so these rows close the run.
        add_row(OP_LOGIC, 5, 5, 0, 0, 0, 1'b1, KIND_REJECT, 1'b0, 0);
        add_row(OP_LOGIC, 9, 3, 0, 0, 0, 1'b1, KIND_REJECT, 1'b0, 0);
        add_row(OP_PHYS, 0, 10, 0, 0, 0, 1'b1, KIND_REJECT, 1'b0, 0);
        add_row(OP_QUERY, 0, 0, 0, 0, 100, 1'b1, KIND_REJECT, 1'b0, 0);
        add_row(OP_UNUSED, 0, 0, 0, 0, 0, 1'b1, KIND_NONE, 1'b0, 0);
        add_row(OP_LOGIC, 0, 100, 0, 0, 0, 1'b1, KIND_REJECT, 1'b0, 0);

        rate_model = RATE_RESET;
        invalidated = 1'b0;
        have_anchor = 1'b0;
        anc_frame = '0;
        anc_tail = '0;
        anc_ms = '0;
        best_frame = '0;
        answered = 1'b0;
        stream_base = 64'd400000;
        stream_ms = 32'd20000;
        mismatch_count = 0;
        stall_req_id = 0;
        stall_cycles_req = 0;
        src_idle_pct = 30;
        sink_idle_pct = 57;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_opcode = OP_QUERY;
        s_presented_frame = '0;
        s_submitted_tail = '0;
        s_system_time_ns = '0;
        s_anchor_time_ms = '0;
        s_now_ms = '0;
        cfg_valid = 1'b0;
        cfg_sample_rate = RATE_RESET;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_rate(RATE_RESET);
        walk_rows(0, EARLY_END);

        for (int blk = 0; blk < N_BLOCKS; blk++) begin
            if (blk < 2) begin
                src_idle_pct = 30;
                sink_idle_pct = 57;
            end else if (blk < 4) begin
                src_idle_pct = 57;
                sink_idle_pct = 30;
            end else begin
                src_idle_pct = 0;
                sink_idle_pct = 0;
            end
            rate = (blk == 4) ? RATE_W'($urandom_range(1, 384000)) : block_rates[blk];
            end_stream();
            write_rate(rate);
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                // Hold the result side off long enough for the pipeline to fill and
                // push back on the input while words keep being offered.
                if (blk == N_BLOCKS - 1 && i == 60) begin
                    stall_cycles_req = STALL_CYCLES;
                    stall_req_id++;
                end
                send_word(well_formed_word(), 1'b0, none_res);
            end
        end

        walk_rows(EARLY_END, EXTREME_END);
        for (int i = 0; i < NOISY_WORDS; i++)
            send_word(noisy_word(), 1'b0, none_res);
        walk_rows(EXTREME_END, stim_table.size());
        end_stream();

        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/apfp_pkg.sv
sv/apfp_ctrl.sv
sv/apfp_ms_div.sv
sv/apfp_proj.sv
sv/apfp_out.sv
sv/audio_presented_frame_projector_unit.sv
tb/tb_audio_presented_frame_projector_unit.sv
